// ----- hw/rtl/flgr_pkg.sv -----
package flgr_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 17;

    // Sequencer states of the per-sample flow.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_INTERP,
        ST_FEEDBACK,
        ST_STORE,
        ST_MIX,
        ST_SWEEP,
        ST_OUT
    } state_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_DELAY    = 3'd1,
        REG_FEEDBACK = 3'd2,
        REG_RATE     = 3'd3,
        REG_DRY      = 3'd4,
        REG_WET      = 3'd5,
        REG_DEPTH    = 3'd6
    } reg_index_t;

    localparam logic [4:0] FEEDBACK_TOP = 5'd19;
    localparam logic [4:0] MIX_TOP      = 5'd20;
    localparam logic [4:0] RATE_TOP     = 5'd25;
    localparam logic [3:0] DELAY_TOP    = 4'd8;

    // Unsigned Q2.15 gains in steps of 0.05, rounded.
    localparam logic [GAIN_W-1:0] GAIN_TABLE [21] = '{
        17'd0,     17'd1638,  17'd3277,  17'd4915,  17'd6554,  17'd8192,
        17'd9830,  17'd11469, 17'd13107, 17'd14746, 17'd16384, 17'd18022,
        17'd19661, 17'd21299, 17'd22938, 17'd24576, 17'd26214, 17'd27853,
        17'd29491, 17'd31130, 17'd32768
    };

    // Gain lookup with the index clamped to the given top entry.
    function automatic logic [GAIN_W-1:0] gain_q15(input logic [4:0] idx,
                                                   input logic [4:0] top);
        logic [4:0] k;
        k = (idx > top) ? top : idx;
        return GAIN_TABLE[k];
    endfunction

    // Sweep rate in tenths of a hertz.
    function automatic logic [6:0] rate_tenths(input logic [4:0] idx);
        logic [4:0] k;
        k = (idx > RATE_TOP) ? RATE_TOP : idx;
        if (k < 5'd10)
            return {2'b00, k} + 7'd1;
        return 7'd10 + 7'd5 * ({2'b00, k} - 7'd9);
    endfunction

    // Saturate a wide signed value to a 24-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607)
            return 24'sh7FFFFF;
        if (v < -48'sd8388608)
            return 24'sh800000;
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/flgr_div.sv -----
// Division by a constant through multiplication with a rounded-up reciprocal.
// The dividend is split in two halves that are multiplied by the reciprocal into
// registered partial products; their sum is then registered as the product, from
// which the quotient is taken by a shift.
module flgr_div #(
    parameter int NW      = 32,
    parameter int DIVISOR = 240000
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int DL = $clog2(DIVISOR);
    localparam int SH = NW + DL;
    localparam int MW = NW + 2;
    localparam int HW = NW - 16;
    localparam int PW = NW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [MW+15:0]   lo_prod_reg;
    logic [HW+MW-1:0] hi_prod_reg;
    logic [PW-1:0]    prod_reg;
    logic             busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= start;
    end

    // Partial products first, then their sum.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_prod_reg <= (MW + 16)'(dividend[15:0]) * (MW + 16)'(RECIP);
            hi_prod_reg <= (HW + MW)'(dividend[NW-1:16]) * (HW + MW)'(RECIP);
        end
        if (busy_reg)
            prod_reg <= PW'(lo_prod_reg) + {hi_prod_reg, 16'b0};
    end

    assign done     = !busy_reg && !start;
    assign quotient = NW'(prod_reg >> SH);

endmodule

// ----- hw/rtl/flanger_delay_modulator.sv -----
// Channel   Direction  Transaction contents
// s_axis    in         one 24-bit signed input sample
// m_axis    out        one 24-bit signed flanged sample
// cfg       in         one register write (index, data), no handshake
//
// A bypassed sample goes from the idle state straight to the output state; an
// effect sample passes idle, prep, read, interp, feedback, store, mix, sweep and
// output in that order. The result is registered as the output state is left.
// After reset the delay store is zeroed one word per cycle, and no sample is
// accepted until the whole store is cleared. A result still waiting on the
// output holds the sequencer in its output state, and no input is taken then.
module flanger_delay_modulator #(
    parameter int STORE_DEPTH = 512,
    parameter int SAMPLE_RATE = 48000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] sample_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int PW   = 8 + AW;
    localparam int SW   = AW + 16;
    localparam int NW   = SW + 7;
    localparam int POSW = AW + 17;
    localparam int DIVISOR = 5 * SAMPLE_RATE;
    localparam logic [AW:0]     DEPTH_C = (AW + 1)'(STORE_DEPTH);
    localparam logic [POSW-1:0] SPAN_C  = POSW'(STORE_DEPTH) << 16;
    localparam logic [PW-1:0]   SHALLOW = PW'(512);
    localparam logic [SW:0]     SHALLOW_OFS = (SW + 1)'(131072);

    // Configuration registers.
    logic       enable_reg;
    logic [3:0] delay_index_reg;
    logic [4:0] feedback_index_reg;
    logic [4:0] rate_index_reg;
    logic [4:0] dry_index_reg;
    logic [4:0] wet_index_reg;
    logic [7:0] sweep_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b0;
            delay_index_reg    <= 4'd3;
            feedback_index_reg <= 5'd5;
            rate_index_reg     <= 5'd4;
            dry_index_reg      <= 5'd15;
            wet_index_reg      <= 5'd15;
            sweep_depth_reg    <= 8'd230;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                flgr_pkg::REG_ENABLE:   enable_reg         <= cfg_data[0];
                flgr_pkg::REG_DELAY:    delay_index_reg    <= cfg_data[3:0];
                flgr_pkg::REG_FEEDBACK: feedback_index_reg <= cfg_data[4:0];
                flgr_pkg::REG_RATE:     rate_index_reg     <= cfg_data[4:0];
                flgr_pkg::REG_DRY:      dry_index_reg      <= cfg_data[4:0];
                flgr_pkg::REG_WET:      wet_index_reg      <= cfg_data[4:0];
                flgr_pkg::REG_DEPTH:    sweep_depth_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Base lag in samples, limited to two less than the store depth.
    function automatic logic [AW-1:0] lag_of(input logic [3:0] idx);
        int v;
        case ((idx > flgr_pkg::DELAY_TOP) ? flgr_pkg::DELAY_TOP : idx)
            4'd0:    v = (2 * SAMPLE_RATE) / 2000;
            4'd1:    v = (3 * SAMPLE_RATE) / 2000;
            4'd2:    v = (4 * SAMPLE_RATE) / 2000;
            4'd3:    v = (5 * SAMPLE_RATE) / 2000;
            4'd4:    v = (6 * SAMPLE_RATE) / 2000;
            4'd5:    v = (7 * SAMPLE_RATE) / 2000;
            4'd6:    v = (8 * SAMPLE_RATE) / 2000;
            4'd7:    v = (9 * SAMPLE_RATE) / 2000;
            default: v = (10 * SAMPLE_RATE) / 2000;
        endcase
        if (v > STORE_DEPTH - 2)
            v = STORE_DEPTH - 2;
        return AW'(v);
    endfunction

    flgr_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clear_reg;
    logic [AW-1:0] wp_reg;
    logic [SW-1:0] offset_reg;
    logic          falling_reg;
    logic          out_valid_reg;
    logic [23:0]   out_data_reg;

    logic signed [23:0] x_reg;
    logic [AW-1:0]      lag_reg;
    logic [SW-1:0]      smax_reg;
    logic [NW-1:0]      num_reg;
    logic [AW-1:0]      i0_reg;
    logic [AW-1:0]      i1_reg;
    logic [15:0]        frac_reg;
    logic signed [23:0] d0_reg;
    logic signed [23:0] d1_reg;
    logic signed [41:0] interp_reg;
    logic signed [23:0] delayed_reg;
    logic signed [41:0] fb_prod_reg;
    logic signed [23:0] stored_reg;
    logic signed [41:0] wet_prod_reg;
    logic signed [41:0] dry_prod_reg;

    logic div_start;
    logic div_done;
    logic [NW-1:0] div_q;

    flgr_div #(
        .NW      (NW),
        .DIVISOR (DIVISOR)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Delay store: two read ports for the interpolation pair, one write port.
    logic signed [23:0] store_mem [STORE_DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [23:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        d0_reg <= store_mem[i0_reg];
        d1_reg <= store_mem[i1_reg];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg;
        mem_wdata = stored_reg;
        if (state_reg == flgr_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_reg;
            mem_wdata = '0;
        end
        else if (state_reg == flgr_pkg::ST_STORE)
        begin
            mem_we    = 1'b1;
            mem_wdata = flgr_pkg::sat24(48'(x_reg) + 48'(fb_prod_reg >>> 15));
        end
    end

    // Sweep limit from depth and lag.
    logic [PW-1:0] depth_lag;
    logic [SW-1:0] smax_now;
    always_comb
    begin
        depth_lag = PW'(sweep_depth_reg) * PW'(lag_of(delay_index_reg));
        smax_now  = (depth_lag > SHALLOW) ?
                    SW'({depth_lag, 8'b0} - SHALLOW_OFS) : '0;
    end

    // Read position: base tap plus sweep offset, wrapped once.
    logic [AW:0]     base_raw;
    logic [AW-1:0]   base;
    logic [POSW-1:0] pos_raw;
    logic [POSW-1:0] pos;
    logic [AW-1:0]   i0_now;
    logic [AW-1:0]   i1_now;
    always_comb
    begin
        base_raw = {1'b0, wp_reg} + DEPTH_C - {1'b0, lag_reg} - (AW + 1)'(1);
        base     = (base_raw >= DEPTH_C) ? AW'(base_raw - DEPTH_C) : base_raw[AW-1:0];
        pos_raw  = (POSW'(base) << 16) + POSW'(offset_reg);
        pos      = (pos_raw >= SPAN_C) ? pos_raw - SPAN_C : pos_raw;
        i0_now   = pos[AW+15:16];
        i1_now   = ({1'b0, i0_now} + (AW + 1)'(1) == DEPTH_C) ? '0 : i0_now + 1'b1;
    end

    // Triangle sweep update.
    logic [SW-1:0] inc;
    logic [SW:0]   sum_up;
    logic [SW:0]   next_val;
    logic          hit_low;
    logic          flip1;
    logic [SW-1:0] offset_new;
    logic          falling_new;
    always_comb
    begin
        inc    = SW'(div_q);
        sum_up = {1'b0, offset_reg} + {1'b0, inc};
        if (falling_reg)
        begin
            hit_low  = (inc >= offset_reg);
            next_val = {1'b0, offset_reg} - {1'b0, inc};
        end
        else
        begin
            hit_low  = (sum_up == '0);
            next_val = sum_up;
        end
        if (hit_low)
            next_val = '0;
        flip1 = falling_reg ^ hit_low;
        if (next_val >= {1'b0, smax_reg})
        begin
            offset_new  = smax_reg;
            falling_new = !flip1;
        end
        else
        begin
            offset_new  = next_val[SW-1:0];
            falling_new = flip1;
        end
    end

    // Next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            flgr_pkg::ST_CLEAR:
                if ({1'b0, clear_reg} + (AW + 1)'(1) == DEPTH_C)
                    state_next = flgr_pkg::ST_IDLE;
            flgr_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = enable_reg ? flgr_pkg::ST_PREP : flgr_pkg::ST_OUT;
            flgr_pkg::ST_PREP:     state_next = flgr_pkg::ST_READ;
            flgr_pkg::ST_READ:
            begin
                div_start  = 1'b1;
                state_next = flgr_pkg::ST_INTERP;
            end
            flgr_pkg::ST_INTERP:   state_next = flgr_pkg::ST_FEEDBACK;
            flgr_pkg::ST_FEEDBACK: state_next = flgr_pkg::ST_STORE;
            flgr_pkg::ST_STORE:    state_next = flgr_pkg::ST_MIX;
            flgr_pkg::ST_MIX:      state_next = flgr_pkg::ST_SWEEP;
            flgr_pkg::ST_SWEEP:
                if (div_done)
                    state_next = flgr_pkg::ST_OUT;
            flgr_pkg::ST_OUT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = flgr_pkg::ST_IDLE;
            default:               state_next = flgr_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flgr_pkg::ST_CLEAR;
            clear_reg     <= '0;
            wp_reg        <= '0;
            offset_reg    <= '0;
            falling_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == flgr_pkg::ST_CLEAR)
                clear_reg <= clear_reg + 1'b1;
            if (state_reg == flgr_pkg::ST_SWEEP && div_done)
            begin
                offset_reg  <= offset_new;
                falling_reg <= falling_new;
                wp_reg      <= ({1'b0, wp_reg} + (AW + 1)'(1) == DEPTH_C) ? '0 :
                               wp_reg + 1'b1;
            end
            if (state_reg == flgr_pkg::ST_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers, one stage of arithmetic per state.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            flgr_pkg::ST_IDLE:
            begin
                x_reg    <= s_axis_tdata;
                lag_reg  <= lag_of(delay_index_reg);
                smax_reg <= smax_now;
            end
            flgr_pkg::ST_PREP:
            begin
                num_reg  <= NW'(smax_reg) * NW'(flgr_pkg::rate_tenths(rate_index_reg));
                i0_reg   <= i0_now;
                i1_reg   <= i1_now;
                frac_reg <= pos[15:0];
            end
            flgr_pkg::ST_INTERP:
                interp_reg <= (42'(d1_reg) - 42'(d0_reg)) * 42'($signed({1'b0, frac_reg}));
            flgr_pkg::ST_FEEDBACK:
            begin
                delayed_reg <= 24'((42'(d0_reg) * 42'sd65536 + interp_reg) >>> 16);
                fb_prod_reg <= 42'(24'(((42'(d0_reg) * 42'sd65536 + interp_reg) >>> 16)))
                    * $signed({1'b0, flgr_pkg::gain_q15(feedback_index_reg,
                                                        flgr_pkg::FEEDBACK_TOP)});
            end
            flgr_pkg::ST_STORE:
                stored_reg <= mem_wdata;
            flgr_pkg::ST_MIX:
            begin
                wet_prod_reg <= 42'(delayed_reg) * $signed({1'b0,
                    flgr_pkg::gain_q15(wet_index_reg, flgr_pkg::MIX_TOP)});
                dry_prod_reg <= 42'(stored_reg) * $signed({1'b0,
                    flgr_pkg::gain_q15(dry_index_reg, flgr_pkg::MIX_TOP)});
            end
            flgr_pkg::ST_SWEEP:
                x_reg <= flgr_pkg::sat24(48'((43'(wet_prod_reg) + 43'(dry_prod_reg)) >>> 15));
            flgr_pkg::ST_OUT:
                if (!out_valid_reg || m_axis_tready)
                    out_data_reg <= x_reg;
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == flgr_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- tb/sv/flanger_delay_modulator_tb.sv -----
module flanger_delay_modulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 512;
    localparam int RATE_HZ = 48000;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Predictor copy of the registers and state.
    logic        fl_enable;
    logic [3:0]  fl_delay;
    logic [4:0]  fl_feedback;
    logic [4:0]  fl_rate;
    logic [4:0]  fl_dry;
    logic [4:0]  fl_wet;
    logic [7:0]  fl_depth;
    logic signed [23:0] echo_mem [DEPTH];
    int unsigned head_pos;
    longint      sweep_pos;
    bit          sweep_down;

    logic [23:0] expected_samples [$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          idle_cycles = 0;
    bit          hold_output = 1'b0;
    bit          random_ready = 1'b0;

    always #5 clk = ~clk;

    flanger_delay_modulator u_top (.*);

    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint q15_of(logic [4:0] idx, logic [4:0] top);
        longint k;
        k = (idx > top) ? top : idx;
        return (k * 32768 + 10) / 20;
    endfunction

    // Model of one sample through the flanger.
    function automatic logic [23:0] flange_sample(logic [23:0] raw);
        longint x, lag, smax, step, tenths, base, pos, frac, d0, d1;
        longint delayed, stored, y, nxt, k;
        int unsigned i0, i1;
        x = longint'($signed(raw));
        if (!fl_enable)
            return raw;
        k = (fl_delay > 8) ? 8 : fl_delay;
        lag = ((k + 2) * RATE_HZ) / 2000;
        if (lag > DEPTH - 2)
            lag = DEPTH - 2;
        smax = longint'(fl_depth) * lag * 256 - 2 * 65536;
        if (smax < 0)
            smax = 0;
        k = (fl_rate > 25) ? 25 : fl_rate;
        tenths = (k < 10) ? k + 1 : 10 + 5 * (k - 9);
        step = (smax * tenths) / (5 * RATE_HZ);
        base = ((longint'(head_pos) - lag - 1) % DEPTH + DEPTH) % DEPTH;
        pos = (base * 65536 + sweep_pos) % (DEPTH * 65536);
        i0 = (pos >> 16) % DEPTH;
        i1 = (i0 + 1) % DEPTH;
        frac = pos & 16'hFFFF;
        d0 = echo_mem[i0];
        d1 = echo_mem[i1];
        delayed = floor_div_pow2(d0 * 65536 + (d1 - d0) * frac, 16);
        stored = clip24(x + floor_div_pow2(delayed * q15_of(fl_feedback,
                                                            flgr_pkg::FEEDBACK_TOP), 15));
        echo_mem[head_pos] = stored[23:0];
        y = clip24(floor_div_pow2(delayed * q15_of(fl_wet, flgr_pkg::MIX_TOP)
                                  + stored * q15_of(fl_dry, flgr_pkg::MIX_TOP), 15));
        nxt = sweep_down ? sweep_pos - step : sweep_pos + step;
        if (nxt <= 0)
        begin
            nxt = 0;
            sweep_down = !sweep_down;
        end
        if (nxt >= smax)
        begin
            nxt = smax;
            sweep_down = !sweep_down;
        end
        sweep_pos = nxt;
        head_pos = (head_pos + 1) % DEPTH;
        return y[23:0];
    endfunction

    // Idle gap before the next sample; the input valid drops only for a gap.
    task automatic wait_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Send one sample; the expectation is queued when the transaction happens.
    // The valid stays high on return so that samples can follow back to back.
    task automatic send_sample(logic [23:0] value);
        s_axis_tdata <= value;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_samples.push_back(flange_sample(value));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count)
        begin
            wait_gap();
            send_sample(24'($urandom()));
        end
    endtask

    // Register write, only while nothing is in flight.
    task automatic write_reg(flgr_pkg::reg_index_t idx, logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            flgr_pkg::REG_ENABLE:   fl_enable = value[0];
            flgr_pkg::REG_DELAY:    fl_delay = value[3:0];
            flgr_pkg::REG_FEEDBACK: fl_feedback = value[4:0];
            flgr_pkg::REG_RATE:     fl_rate = value[4:0];
            flgr_pkg::REG_DRY:      fl_dry = value[4:0];
            flgr_pkg::REG_WET:      fl_wet = value[4:0];
            flgr_pkg::REG_DEPTH:    fl_depth = value;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [7:0] dl, logic [7:0] fb, logic [7:0] rt,
                           logic [7:0] dr, logic [7:0] wt, logic [7:0] dp);
        write_reg(flgr_pkg::REG_DELAY, dl);
        write_reg(flgr_pkg::REG_FEEDBACK, fb);
        write_reg(flgr_pkg::REG_RATE, rt);
        write_reg(flgr_pkg::REG_DRY, dr);
        write_reg(flgr_pkg::REG_WET, wt);
        write_reg(flgr_pkg::REG_DEPTH, dp);
    endtask

    task automatic test_bypass();
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_random(40);
    endtask

    task automatic test_extremes();
        write_reg(flgr_pkg::REG_ENABLE, 8'd1);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        // Top feedback and full mix push the sum into saturation.
        set_all(8'd0, 8'd19, 8'd25, 8'd20, 8'd20, 8'd255);
        repeat (8) send_sample(24'h7FFFFF);
        repeat (8) send_sample(24'h800000);
    endtask

    task automatic test_index_clamp();
        // Indexes past the tables, and a sweep too shallow to move.
        set_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0);
        send_random(40);
        set_all(8'd15, 8'd31, 8'd31, 8'd21, 8'd21, 8'd1);
        send_random(40);
    endtask

    task automatic test_random_settings();
        repeat (6)
        begin
            set_all(8'($urandom_range(0, 9)), 8'($urandom_range(0, 20)),
                    8'($urandom_range(0, 26)), 8'($urandom_range(0, 21)),
                    8'($urandom_range(0, 21)), 8'($urandom_range(0, 255)));
            // A stretch of random samples under each setting.
            send_random(80);
        end
    endtask

    task automatic test_backpressure();
        set_all(8'd8, 8'd10, 8'd25, 8'd10, 8'd10, 8'd255);
        hold_output = 1'b1;
        send_random(80);
    endtask

    task automatic test_toggle_enable();
        write_reg(flgr_pkg::REG_ENABLE, 8'd0);
        send_random(20);
        write_reg(flgr_pkg::REG_ENABLE, 8'd1);
        set_all(8'd3, 8'd5, 8'd4, 8'd15, 8'd15, 8'd230);
        send_random(60);
    endtask

    // Output ready: random gaps, with one long hold-off on request.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_output = 1'b0;
            end
            if (random_ready && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n - 1) @(negedge clk);
        end
    end

    // Compare each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out with nothing expected: actual %0d", $signed(m_axis_tdata));
                error_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                checked_count++;
                if (m_axis_tdata !== want)
                begin
                    $error("sample_out expected %0d actual %0d", $signed(want),
                           $signed(m_axis_tdata));
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int settle;
        fl_enable = 1'b0;
        fl_delay = 4'd3;
        fl_feedback = 5'd5;
        fl_rate = 5'd4;
        fl_dry = 5'd15;
        fl_wet = 5'd15;
        fl_depth = 8'd230;
        foreach (echo_mem[i])
            echo_mem[i] = '0;
        head_pos = 0;
        sweep_pos = 0;
        sweep_down = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        random_ready = 1'b1;

        test_bypass();
        test_extremes();
        test_index_clamp();
        test_random_settings();
        test_backpressure();
        test_toggle_enable();

        s_axis_tvalid <= 1'b0;
        settle = 0;
        while (expected_samples.size() != 0 && settle < STALL_LIMIT)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (100) @(negedge clk);
        $display("Sent %0d samples, checked %0d outputs over bypass, saturation,", sent_count,
                 checked_count);
        $display("clamped indexes, random settings and a long output stall.");
        if (error_count == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/flgr_pkg.sv
hw/rtl/flgr_div.sv
hw/rtl/flanger_delay_modulator.sv
tb/sv/flanger_delay_modulator_tb.sv
